[design/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/dmsc_pkg.sv]
package dmsc_pkg;

   localparam int KEY_W   = 64;
   localparam int SCORE_W = 16;
   localparam int MASK_W  = 64;
   localparam int COUNT_W = 11;

   localparam logic [2:0] KIND_STORE         = 3'd0;
   localparam logic [2:0] KIND_PROBE         = 3'd1;
   localparam logic [2:0] KIND_SHELTER_PROBE = 3'd2;
   localparam logic [2:0] KIND_SHELTER_STORE = 3'd3;
   localparam logic [2:0] KIND_CLEAR         = 3'd4;

   // One side's shelter sub-entry.
   typedef struct packed {
      logic               valid;
      logic [3:0]         flags;
      logic [2:0]         file;
      logic [SCORE_W-1:0] score_b;
      logic [SCORE_W-1:0] score_a;
   } sub_type;

   // One table row: the main entry plus both sides' sub-entries.
   typedef struct packed {
      logic [KEY_W-1:0]   tag;
      logic [SCORE_W-1:0] score_b;
      logic [SCORE_W-1:0] score_a;
      logic [MASK_W-1:0]  mask_first;
      logic [MASK_W-1:0]  mask_second;
      sub_type [1:0]      sub;
   } row_type;

   localparam int ROW_W = $bits(row_type);

endpackage

[design/dmsc_ram.sv]
module dmsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/dmsc_slot.sv]
module dmsc_slot #(
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     load,
   input  logic [dmsc_pkg::KEY_W-1:0]               key,
   input  logic [$clog2(DEPTH+1)-1:0]               count,
   output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] slot
);

   localparam int NW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = 32 + NW;

   // Partial products of key times count, one per 32-bit half of the key.
   logic [PW-1:0] hi_ff, hi_in;
   logic [PW-1:0] lo_ff, lo_in;
   logic [PW:0]   sum;
   logic [NW:0]   top;

   assign hi_in = PW'(key[63:32]) * PW'(count);
   assign lo_in = PW'(key[31:0]) * PW'(count);

   always_ff @(posedge clock) begin
      if (load) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign sum = (PW+1)'(hi_ff) + (PW+1)'(lo_ff[PW-1:32]);
   assign top = sum[PW:32];

   always_comb begin
      if (top >= (NW+1)'(DEPTH)) begin
         slot = AW'(DEPTH - 1);
      end else begin
         slot = top[AW-1:0];
      end
   end

endmodule

[design/direct_mapped_score_cache_unit.sv]
// Direct-mapped score cache. Each request beat carries one of five kinds
// (store, probe, shelter probe, shelter store, clear) and selects a table row
// by the upper bits of the whole key times the active entry count. All table
// state sits in one single-port-write, registered-read RAM of DEPTH rows;
// each row holds the tag, scores, masks and both sides' shelter sub-entries.
// A request passes a read state, which finishes the index sum and issues the
// RAM read, then an evaluate state, which compares the tag and writes the
// modified row back. A new beat is taken in the evaluate state, before the
// last one is through, and a store followed by a probe of the same row sees
// the new data because the write lands before the next read is issued.
// Probes and shelter probes return one response beat; the response sits in
// an output register and only holds up the block when a second response is
// due before the first was taken. After reset, and after every clear
// request, the block sweeps the RAM one row per cycle and takes no request
// beat meanwhile; configuration writes are taken at any time. The entry
// count register reads 0 as 1 and clamps values above DEPTH to DEPTH.
module direct_mapped_score_cache_unit #(
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_kind,
   input  logic [dmsc_pkg::KEY_W-1:0]            req_position_key,
   input  logic signed [dmsc_pkg::SCORE_W-1:0]   req_score_a,
   input  logic signed [dmsc_pkg::SCORE_W-1:0]   req_score_b,
   input  logic [dmsc_pkg::MASK_W-1:0]           req_mask_first,
   input  logic [dmsc_pkg::MASK_W-1:0]           req_mask_second,
   input  logic                                  req_side_sel,
   input  logic [2:0]                            req_file_tag,
   input  logic [3:0]                            req_flags_tag,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic signed [dmsc_pkg::SCORE_W-1:0]   rsp_out_score_a,
   output logic signed [dmsc_pkg::SCORE_W-1:0]   rsp_out_score_b,
   output logic [dmsc_pkg::MASK_W-1:0]           rsp_out_mask_first,
   output logic [dmsc_pkg::MASK_W-1:0]           rsp_out_mask_second,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dmsc_pkg::COUNT_W-1:0]          csr_data
);

   localparam int NW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;
   localparam logic [1:0] ST_SWEEP = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [NW-1:0] count_ff, count_in;

   // Request registers, loaded on each accepted beat.
   logic [2:0]                   kind_ff;
   logic [dmsc_pkg::KEY_W-1:0]   key_ff;
   logic [dmsc_pkg::SCORE_W-1:0] sa_ff, sb_ff;
   logic [dmsc_pkg::MASK_W-1:0]  m1_ff, m2_ff;
   logic                         side_ff;
   logic [2:0]                   file_ff;
   logic [3:0]                   flags_ff;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         hit_ff, hit_in;
   logic [dmsc_pkg::SCORE_W-1:0] osa_ff, osa_in, osb_ff, osb_in;
   logic [dmsc_pkg::MASK_W-1:0]  om1_ff, om1_in, om2_ff, om2_in;

   logic req_accept;
   logic eval_go;
   logic has_rsp;
   logic [AW-1:0] slot;

   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [dmsc_pkg::ROW_W-1:0]     wr_data;
   logic [dmsc_pkg::ROW_W-1:0]     rd_data;
   dmsc_pkg::row_type              row_rd;
   dmsc_pkg::row_type              row_wr;
   dmsc_pkg::sub_type              sub_rd;
   logic                           do_write;
   logic                           tag_match;
   logic [31:0]                    cfg_wide;

   dmsc_slot #(.DEPTH(DEPTH)) u_slot (
      .clock (clock),
      .load  (req_accept),
      .key   (req_position_key),
      .count (count_ff),
      .slot  (slot)
   );

   dmsc_ram #(.WIDTH(dmsc_pkg::ROW_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   // The entry count is clamped once, when it is written.
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_wide = {{(32 - dmsc_pkg::COUNT_W){1'b0}}, csr_data};
      if (cfg_wide == 32'd0) begin
         cfg_wide = 32'd1;
      end else if (cfg_wide > 32'(DEPTH)) begin
         cfg_wide = 32'(DEPTH);
      end
      count_in = count_ff;
      if (csr_valid) begin
         count_in = cfg_wide[NW-1:0];
      end
   end

   // Row compare and modify, in the evaluate cycle.
   assign row_rd    = dmsc_pkg::row_type'(rd_data);
   assign tag_match = (row_rd.tag == key_ff);
   assign sub_rd    = row_rd.sub[side_ff];
   assign has_rsp   = (kind_ff == dmsc_pkg::KIND_PROBE) ||
                      (kind_ff == dmsc_pkg::KIND_SHELTER_PROBE);

   // The evaluate cycle only waits when its response would overwrite one
   // that has not been taken yet.
   assign eval_go = (state_ff == ST_EVAL) && !(has_rsp && rsp_valid_ff && !rsp_ready);

   always_comb begin
      row_wr   = row_rd;
      do_write = 1'b0;
      hit_in   = 1'b0;
      osa_in   = '0;
      osb_in   = '0;
      om1_in   = '0;
      om2_in   = '0;
      case (kind_ff)
         dmsc_pkg::KIND_STORE: begin
            do_write = 1'b1;
            if (!tag_match) begin
               row_wr.sub[0].valid = 1'b0;
               row_wr.sub[1].valid = 1'b0;
            end
            row_wr.tag         = key_ff;
            row_wr.score_a     = sa_ff;
            row_wr.score_b     = sb_ff;
            row_wr.mask_first  = m1_ff;
            row_wr.mask_second = m2_ff;
         end
         dmsc_pkg::KIND_PROBE: begin
            if (tag_match) begin
               hit_in = 1'b1;
               osa_in = row_rd.score_a;
               osb_in = row_rd.score_b;
               om1_in = row_rd.mask_first;
               om2_in = row_rd.mask_second;
            end
         end
         dmsc_pkg::KIND_SHELTER_PROBE: begin
            if (tag_match && sub_rd.valid &&
                {sub_rd.flags, sub_rd.file} == {flags_ff, file_ff}) begin
               hit_in = 1'b1;
               osa_in = sub_rd.score_a;
               osb_in = sub_rd.score_b;
            end
         end
         dmsc_pkg::KIND_SHELTER_STORE: begin
            if (tag_match) begin
               do_write                    = 1'b1;
               row_wr.sub[side_ff].valid   = 1'b1;
               row_wr.sub[side_ff].flags   = flags_ff;
               row_wr.sub[side_ff].file    = file_ff;
               row_wr.sub[side_ff].score_a = sa_ff;
               row_wr.sub[side_ff].score_b = sb_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // The sweep owns the write port; otherwise the evaluate cycle writes back.
   always_comb begin
      if (state_ff == ST_SWEEP) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff;
         wr_data = '0;
      end else begin
         wr_en   = eval_go && do_write;
         wr_addr = slot;
         wr_data = dmsc_pkg::ROW_W'(row_wr);
      end
   end

   // A new beat is taken while idle, or in the evaluate cycle that is about
   // to finish, unless that item starts a sweep.
   assign req_ready  = (state_ff == ST_IDLE) ||
                       (eval_go && (kind_ff != dmsc_pkg::KIND_CLEAR));
   assign req_accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (eval_go) begin
               if (kind_ff == dmsc_pkg::KIND_CLEAR) begin
                  state_in = ST_SWEEP;
                  ptr_in   = '0;
               end else if (req_accept) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SWEEP: begin
            if (ptr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
               ptr_in   = '0;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (eval_go && has_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         ptr_ff       <= '0;
         count_ff     <= NW'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_kind;
         key_ff   <= req_position_key;
         sa_ff    <= req_score_a;
         sb_ff    <= req_score_b;
         m1_ff    <= req_mask_first;
         m2_ff    <= req_mask_second;
         side_ff  <= req_side_sel;
         file_ff  <= req_file_tag;
         flags_ff <= req_flags_tag;
      end
      if (eval_go && has_rsp) begin
         hit_ff <= hit_in;
         osa_ff <= osa_in;
         osb_ff <= osb_in;
         om1_ff <= om1_in;
         om2_ff <= om2_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_out_score_a     = osa_ff;
   assign rsp_out_score_b     = osb_ff;
   assign rsp_out_mask_first  = om1_ff;
   assign rsp_out_mask_second = om2_ff;

endmodule

[design/dmsc_checker.sv]
`include "assert_macros.svh"

module dmsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [15:0] rsp_out_score_a,
   input logic [15:0] rsp_out_score_b,
   input logic [63:0] rsp_out_mask_first,
   input logic [63:0] rsp_out_mask_second
);

   // A stalled response beat stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // A miss carries all-zero data.
   `ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, (rsp_out_score_a == 16'd0) && (rsp_out_score_b == 16'd0) && (rsp_out_mask_first == 64'd0) && (rsp_out_mask_second == 64'd0), "miss with nonzero data")

   // Reset starts the clearing sweep, so no request beat is taken right after.
   `ASSERT_NEXT(a_reset_sweep, clock, 1'b0, reset, !req_ready, "request taken during reset sweep")

   // Every request needs a read cycle before the next beat can be taken.
   `ASSERT_NEXT(a_req_spacing, clock, reset, req_valid && req_ready, !req_ready, "request beats too close")

endmodule

bind direct_mapped_score_cache_unit dmsc_checker u_dmsc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_hit             (rsp_hit),
   .rsp_out_score_a     (rsp_out_score_a),
   .rsp_out_score_b     (rsp_out_score_b),
   .rsp_out_mask_first  (rsp_out_mask_first),
   .rsp_out_mask_second (rsp_out_mask_second)
);
